[rtl/core/ibt_pkg.sv]
// shared constants, status codes and control structs for the interval booking table
// used by every module under rtl/core; depends on nothing else
`default_nettype none

package ibt_pkg;

    // table size and time field width
    localparam int CAPACITY   = 1024;
    localparam int TIME_BITS  = 30;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // stream packing: two time fields in, one status out, padded to bytes
    localparam int STATUS_BITS   = 2;
    localparam int IN_DATA_BITS  = ((2 * TIME_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((STATUS_BITS + 7) / 8) * 8;

    // result codes
    localparam logic [STATUS_BITS-1:0] ST_BOOKED  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OVERLAP = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [ADDR_BITS-1:0] addr_t;

    // write port of the interval store
    typedef struct packed {
        logic  en;
        addr_t addr;
        time_t start_time;
        time_t end_time;
    } mem_wr_t;

    // read port of the interval store
    typedef struct packed {
        logic  en;
        addr_t addr;
    } mem_rd_t;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic                   valid;
        logic [STATUS_BITS-1:0] status;
    } resp_t;

endpackage

`default_nettype wire

[rtl/core/ibt_mem.sv]
// interval store: one write port, one registered read port
// depends on ibt_pkg for widths and port structs
`default_nettype none

module ibt_mem (
    input  wire logic            clk,
    input  wire ibt_pkg::mem_wr_t wr,
    input  wire ibt_pkg::mem_rd_t rd,
    output ibt_pkg::time_t       rd_start,
    output ibt_pkg::time_t       rd_end
);

    // each word holds end time above start time
    logic [2*ibt_pkg::TIME_BITS-1:0] mem [ibt_pkg::CAPACITY];
    logic [2*ibt_pkg::TIME_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.end_time, wr.start_time};
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_start = rd_data_reg[ibt_pkg::TIME_BITS-1:0];
    assign rd_end   = rd_data_reg[2*ibt_pkg::TIME_BITS-1:ibt_pkg::TIME_BITS];

endmodule

`default_nettype wire

[rtl/core/ibt_seq.sv]
// request sequencer: walks the stored intervals through one comparator pair,
// then appends or rejects; depends on ibt_pkg
`default_nettype none

module ibt_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ibt_pkg::time_t   in_start,
    input  wire ibt_pkg::time_t   in_end,
    output ibt_pkg::mem_wr_t      wr,
    output ibt_pkg::mem_rd_t      rd,
    input  wire ibt_pkg::time_t   rd_start,
    input  wire ibt_pkg::time_t   rd_end,
    output ibt_pkg::resp_t        resp,
    input  wire logic             resp_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_BOOK = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    localparam logic [ibt_pkg::COUNT_BITS-1:0] FULL_COUNT =
        ibt_pkg::COUNT_BITS'(ibt_pkg::CAPACITY);

    logic [1:0]                       state_reg, state_next;
    logic [ibt_pkg::COUNT_BITS-1:0]   count_reg, count_next;
    logic [ibt_pkg::COUNT_BITS-1:0]   idx_reg, idx_next;
    logic                             rd_vld_reg, rd_vld_next;
    logic [ibt_pkg::STATUS_BITS-1:0]  status_reg, status_next;
    ibt_pkg::time_t                   start_reg, start_next;
    ibt_pkg::time_t                   end_reg, end_next;

    logic issue;
    logic overlap;

    // shared comparator pair against the entry read last cycle
    assign overlap = (start_reg < rd_end) && (end_reg > rd_start);
    assign issue   = (state_reg == S_SCAN) && (idx_reg < count_reg);

    assign in_ready = (state_reg == S_IDLE);

    assign rd.en   = issue;
    assign rd.addr = idx_reg[ibt_pkg::ADDR_BITS-1:0];

    assign wr.en         = (state_reg == S_BOOK);
    assign wr.addr       = count_reg[ibt_pkg::ADDR_BITS-1:0];
    assign wr.start_time = start_reg;
    assign wr.end_time   = end_reg;

    assign resp.valid  = (state_reg == S_RESP);
    assign resp.status = status_reg;

    // next-state logic
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rd_vld_next = 1'b0;
        status_next = status_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    start_next = in_start;
                    end_next   = in_end;
                    idx_next   = '0;
                    if (count_reg == FULL_COUNT)
                    begin
                        status_next = ibt_pkg::ST_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // early exit on the first conflict
                if (rd_vld_reg && overlap)
                begin
                    status_next = ibt_pkg::ST_OVERLAP;
                    state_next  = S_RESP;
                end
                else
                begin
                    rd_vld_next = issue;
                    if (issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    else if (!rd_vld_reg)
                    begin
                        state_next = S_BOOK;
                    end
                end
            end
            S_BOOK:
            begin
                count_next  = count_reg + 1'b1;
                status_next = ibt_pkg::ST_BOOKED;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (resp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
    end

endmodule

`default_nettype wire

[rtl/core/interval_booking_table.sv]
// top level of the interval booking table: stream ports, output register,
// sequencer and interval store; depends on ibt_pkg, ibt_mem, ibt_seq
//
//   channel  | direction | payload
//   s_axis   | in        | start_time, end_time (one booking request)
//   m_axis   | out       | status (one per request)
//
// a booked request is checked against all n stored entries, n the fill count, then
// appended; an overlap answers once the first conflicting entry has been read;
// the scan reads one entry per cycle; a full table answers without a scan
// reset clears the fill count and control state, but not the interval store
// the finished result sits in the output register, so a stalled m_axis side
// does not hold back the next request, which then waits only to hand its result over
`default_nettype none

module interval_booking_table (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [29:0] start_time, [59:30] end_time, rest zero
    input  wire logic [ibt_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] status, rest zero
    output logic [ibt_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata
);

    ibt_pkg::mem_wr_t wr;
    ibt_pkg::mem_rd_t rd;
    ibt_pkg::time_t   rd_start;
    ibt_pkg::time_t   rd_end;
    ibt_pkg::resp_t   resp;
    logic             resp_ready;

    logic                             out_valid_reg;
    logic [ibt_pkg::STATUS_BITS-1:0]  out_status_reg;

    // output register frees whenever it is empty or being drained
    assign resp_ready = !out_valid_reg || m_axis_tready;

    ibt_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_start   (s_axis_tdata[ibt_pkg::TIME_BITS-1:0]),
        .in_end     (s_axis_tdata[2*ibt_pkg::TIME_BITS-1:ibt_pkg::TIME_BITS]),
        .wr         (wr),
        .rd         (rd),
        .rd_start   (rd_start),
        .rd_end     (rd_end),
        .resp       (resp),
        .resp_ready (resp_ready)
    );

    ibt_mem u_mem (
        .clk      (clk),
        .wr       (wr),
        .rd       (rd),
        .rd_start (rd_start),
        .rd_end   (rd_end)
    );

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (resp_ready)
        begin
            out_valid_reg <= resp.valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (resp_ready && resp.valid)
        begin
            out_status_reg <= resp.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(ibt_pkg::OUT_DATA_BITS - ibt_pkg::STATUS_BITS){1'b0}},
                            out_status_reg};

`ifndef SYNTHESIS
    // sequencer is busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    // a finished result is never offered while new requests are open
    a_resp_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid |-> !s_axis_tready)
        else $error("input open while result pending");

    // a handed-over result shows up on the output next cycle
    a_resp_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && resp_ready |=> m_axis_tvalid)
        else $error("result lost on way to output register");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ibt_pkg::STATUS_BITS-1:0] == ibt_pkg::ST_BOOKED
                           || m_axis_tdata[ibt_pkg::STATUS_BITS-1:0] == ibt_pkg::ST_OVERLAP
                           || m_axis_tdata[ibt_pkg::STATUS_BITS-1:0] == ibt_pkg::ST_FULL))
        else $error("undefined status code on output");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking bench for interval_booking_table: booking requests on s_axis,
// status per request on m_axis, checked against an in-bench model of the table
// depends on ibt_pkg and the interval_booking_table rtl

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam ibt_pkg::time_t MAX_TIME  = '1;
    localparam int unsigned SLOT_W       = 1 << 19;
    localparam int unsigned NUM_SLOTS    = 1024;
    localparam int unsigned SLOT_BASE    = 1024;
    localparam int unsigned RANDOM_ITEMS = 580;
    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned PRINT_LIMIT  = 100;

    typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                                s_axis_tvalid = 1'b0;
    logic                                clk           = 1'b0;
    logic                                rst_n         = 1'b0;
    logic                                s_axis_tready;
    logic [ibt_pkg::IN_DATA_BITS-1:0]    s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [ibt_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;

    // model of the table, advanced once per accepted request
    ibt_pkg::time_t booked_start [ibt_pkg::CAPACITY];
    ibt_pkg::time_t booked_end   [ibt_pkg::CAPACITY];
    int unsigned    booked_count = 0;

    // statuses owed by the block, oldest first
    logic [ibt_pkg::STATUS_BITS-1:0] status_due [$];

    int unsigned errors       = 0;
    int unsigned n_requests   = 0;
    int unsigned n_booked     = 0;
    int unsigned n_overlap    = 0;
    int unsigned n_full       = 0;
    bit          sender_gaps  = 1'b1;
    int unsigned burst_left   = 0;

    interval_booking_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch at %0t ns: %s", $realtime, msg);
    endtask

    // status of one request against the table, and the table update it causes
    function automatic logic [ibt_pkg::STATUS_BITS-1:0] booking_status(
        input ibt_pkg::time_t t_start,
        input ibt_pkg::time_t t_end);
        int unsigned k;
        bit          clash;
        clash = 1'b0;
        n_requests++;
        if (booked_count >= ibt_pkg::CAPACITY)
        begin
            n_full++;
            return ibt_pkg::ST_FULL;
        end
        for (k = 0; k < booked_count; k++)
        begin
            if (t_start < booked_end[k] && t_end > booked_start[k])
                clash = 1'b1;
        end
        if (clash)
        begin
            n_overlap++;
            return ibt_pkg::ST_OVERLAP;
        end
        booked_start[booked_count] = t_start;
        booked_end[booked_count]   = t_end;
        booked_count++;
        n_booked++;
        return ibt_pkg::ST_BOOKED;
    endfunction

    function automatic ibt_pkg::time_t clip_time(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(MAX_TIME))
            return MAX_TIME;
        return ibt_pkg::TIME_BITS'(v);
    endfunction

    // one request transaction; enter and leave at a falling edge, tvalid left high
    task automatic send_request(input ibt_pkg::time_t t_start, input ibt_pkg::time_t t_end);
        int unsigned gap;
        gap = 0;
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {{(ibt_pkg::IN_DATA_BITS - 2 * ibt_pkg::TIME_BITS){1'b0}},
                          t_end, t_start};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        status_due.push_back(booking_status(t_start, t_end));
        @(negedge clk);
    endtask

    // hold the sender until every owed status has come back
    task automatic wait_for_results();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (status_due.size() != 0)
            report_mismatch($sformatf("%0d statuses missing", status_due.size()));
        @(negedge clk);
    endtask

    // status checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (status_due.size() == 0)
                report_mismatch($sformatf("status %0d with no request pending",
                                          m_axis_tdata[ibt_pkg::STATUS_BITS-1:0]));
            else if (m_axis_tdata[ibt_pkg::STATUS_BITS-1:0] != status_due[0])
                report_mismatch($sformatf("status %0d, expected %0d",
                                          m_axis_tdata[ibt_pkg::STATUS_BITS-1:0],
                                          status_due[0]));
            if (m_axis_tdata[ibt_pkg::OUT_DATA_BITS-1:ibt_pkg::STATUS_BITS] != '0)
                report_mismatch("tdata padding bits not zero");
            if (status_due.size() != 0)
                void'(status_due.pop_front());
        end
    end

    // receiver stall patterns, switched at random among four modes
    initial
    begin
        int unsigned cyc;
        rx_mode_t    mode;
        cyc  = 0;
        mode = RX_ALWAYS;
        forever
        begin
            @(negedge clk);
            if (cyc % 64 == 0)
                mode = rx_mode_t'($urandom_range(0, 3));
            case (mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= (cyc % 7 == 0);
                default:   m_axis_tready <= (cyc % 3 != 0);
            endcase
            cyc++;
        end
    end

    // overlap rules on small hand-picked intervals
    task automatic test_basic_overlaps();
        send_request(100, 200);     // empty table books
        send_request(100, 200);     // identical interval
        send_request(150, 160);     // strictly inside
        send_request(50, 150);      // overlaps the left part
        send_request(199, 300);     // overlaps the right part
        send_request(200, 300);     // touches the end, half-open so it books
        send_request(0, 100);       // touches the start
        send_request(0, 0);         // empty interval at zero
        send_request(150, 150);     // empty interval strictly inside a booking
        send_request(100, 100);     // empty interval on a booked start
        wait_for_results();
    endtask

    // field extremes, inverted intervals and values past the nominal range
    task automatic test_extreme_values();
        send_request(0, MAX_TIME);              // whole range
        send_request(MAX_TIME, MAX_TIME);
        send_request(MAX_TIME, 0);              // inverted, end at zero
        send_request(250, 120);                 // inverted, small
        send_request(50, 400);                  // spans several bookings
        send_request(1_000_000_007, 1_000_000_009);
        send_request(1_000_000_008, MAX_TIME);
        send_request(MAX_TIME - 1'b1, MAX_TIME);
        wait_for_results();
    endtask

    // mostly well-formed requests spread over slots, plus deliberate overlaps and noise
    task automatic test_random_bookings();
        int unsigned    i;
        int unsigned    pick;
        int unsigned    idx;
        longint         base;
        longint         pt;
        ibt_pkg::time_t t_start;
        ibt_pkg::time_t t_end;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 97 == 96)
                wait_for_results();
            sender_gaps = !(i >= 200 && i < 280);
            pick = $urandom_range(0, 99);
            base = SLOT_BASE + longint'($urandom_range(0, NUM_SLOTS - 1)) * SLOT_W;
            idx  = (booked_count == 0) ? 0 : $urandom_range(0, booked_count - 1);
            if (pick < 45 || (pick < 77 && booked_count == 0))
            begin
                // fresh interval in a random slot
                pt      = base + $urandom_range(0, SLOT_W - 1);
                t_start = clip_time(pt);
                t_end   = clip_time(pt + $urandom_range(1, SLOT_W / 2));
            end
            else if (pick < 65)
            begin
                // straddles a point of a stored interval
                if (booked_start[idx] < booked_end[idx])
                    pt = longint'(booked_start[idx])
                       + $urandom_range(0, booked_end[idx] - booked_start[idx] - 1);
                else
                    pt = booked_start[idx];
                t_start = clip_time(pt - $urandom_range(0, 3000));
                t_end   = clip_time(pt + 1 + $urandom_range(0, 3000));
            end
            else if (pick < 77)
            begin
                // abuts a stored interval on one side
                if ($urandom_range(0, 1))
                begin
                    t_start = booked_end[idx];
                    t_end   = clip_time(longint'(booked_end[idx]) + $urandom_range(1, 5000));
                end
                else
                begin
                    t_end   = booked_start[idx];
                    t_start = clip_time(longint'(booked_start[idx]) - $urandom_range(1, 5000));
                end
            end
            else if (pick < 88)
            begin
                // empty or inverted
                pt      = base + $urandom_range(0, SLOT_W - 1);
                t_start = clip_time(pt);
                t_end   = clip_time(pt - $urandom_range(0, 2000));
            end
            else if (pick < 94)
            begin
                t_start = ibt_pkg::TIME_BITS'($urandom_range(0, MAX_TIME));
                t_end   = ibt_pkg::TIME_BITS'($urandom_range(0, MAX_TIME));
            end
            else
            begin
                // one field pinned at an extreme
                pt = longint'($urandom_range(0, MAX_TIME));
                case ($urandom_range(0, 3))
                    0:
                    begin
                        t_start = 0;
                        t_end   = ibt_pkg::TIME_BITS'(pt);
                    end
                    1:
                    begin
                        t_start = ibt_pkg::TIME_BITS'(pt);
                        t_end   = MAX_TIME;
                    end
                    2:
                    begin
                        t_start = MAX_TIME;
                        t_end   = ibt_pkg::TIME_BITS'(pt);
                    end
                    default:
                    begin
                        t_start = ibt_pkg::TIME_BITS'(pt);
                        t_end   = 0;
                    end
                endcase
            end
            send_request(t_start, t_end);
        end
        sender_gaps = 1'b1;
        wait_for_results();
    endtask

    // fill the table, then probe the full answer
    task automatic test_fill_to_capacity();
        int unsigned i;
        // an end of zero never overlaps, so each of these books
        while (booked_count < ibt_pkg::CAPACITY)
            send_request(ibt_pkg::TIME_BITS'($urandom_range(0, MAX_TIME)), 0);
        send_request(0, 0);
        send_request(MAX_TIME, MAX_TIME);
        send_request(0, MAX_TIME);
        for (i = 0; i < 5; i++)
            send_request(ibt_pkg::TIME_BITS'($urandom_range(0, MAX_TIME)),
                         ibt_pkg::TIME_BITS'($urandom_range(0, MAX_TIME)));
        wait_for_results();
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_basic_overlaps();
        test_extreme_values();
        test_random_bookings();
        test_fill_to_capacity();
        // allow any stray status to show
        repeat (ibt_pkg::CAPACITY + 8) @(negedge clk);
        $display("covered %0d requests: %0d booked, %0d overlapping, %0d table full",
                 n_requests, n_booked, n_overlap, n_full);
        $display("table reached %0d of %0d entries, %0d mismatches",
                 booked_count, ibt_pkg::CAPACITY, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
